// File: src/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Channel field width and the number of channels it can name
  localparam int CHAN_W        = 4;
  localparam int CHAN_FIELD_N  = 1 << CHAN_W;
  localparam int NUM_CHANNELS_DEF = 16;

  // Header is 2 magic bytes plus 8 length bytes
  localparam logic [3:0] HEADER_BYTES = 4'd10;
  localparam logic [3:0] MAGIC_BYTES  = 4'd2;

  // Per-channel parse phase codes (code 3 behaves as header)
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_OPCODE  = 2'd1;
  localparam logic [1:0] PH_MESSAGE = 2'd2;

  // Input word: one received byte tagged with its channel
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [7:0]        data_byte;
  } in_word_t;

  // Output word: one emitted message byte or frame event
  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [15:0]       frame_magic;
    logic [7:0]        frame_opcode;
    logic [7:0]        message_byte;
    logic              has_byte;
    logic              frame_last;
    logic              frame_error;
  } out_word_t;

  // Parse context kept for each channel
  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  header_count;
    logic [15:0] magic;
    logic [63:0] remaining;
    logic [7:0]  opcode;
  } chan_state_t;

endpackage

// File: src/length_prefixed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core
// Per-channel deframer for length-prefixed frames, one byte per cycle while results are not blocked.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of received bytes, each tagged with a channel.
//   out_* : valid/ready channel of results, one per message byte, plus one per
//           opcode-only frame and one per zero-length (error) header.
//   A frame is 2 magic bytes, an 8-byte body length (both LSB first), then an
//   opcode byte and length-1 message bytes. Bytes on channels at or above
//   NUM_CHANNELS are dropped without a result.
// Timing:
//   An accepted byte sits in the input register, where it is parsed against
//   its channel context and loaded into the output register, so a result
//   passes the input and then the output register before out_valid is set.
//   Throughput is one byte per cycle while the output is not blocked, set by
//   the single read-modify-write of the channel context table per cycle.
// Reset and stall:
//   rst clears all channel contexts to header phase and empties both
//   registers. While out_ready is low the output word holds; bytes that make
//   no result keep flowing, and a byte that needs the output waits in the
//   input register, dropping in_ready.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core
  import lpd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int DEPTH = (NUM_CHANNELS < CHAN_FIELD_N) ? NUM_CHANNELS : CHAN_FIELD_N;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic        stg_valid;
  in_word_t    stg_word;
  logic        ch_ok;
  logic        out_free;
  logic        stg_go;
  logic        step_emit;
  logic        res_emit;
  chan_state_t cur_ctx;
  chan_state_t nxt_ctx;
  out_word_t   step_res;
  logic [IDX_W-1:0] ch_idx;

  // Channel range check and table index
  assign ch_ok  = (32'(stg_word.channel) < NUM_CHANNELS);
  assign ch_idx = IDX_W'(stg_word.channel);

  // Handshake: stage advances unless its result is blocked
  assign res_emit = step_emit && ch_ok;
  assign out_free = !out_valid || out_ready;
  assign stg_go   = stg_valid && (!res_emit || out_free);
  assign in_ready = !stg_valid || stg_go;

  lpd_chan_regs #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (ch_idx),
    .rd_data (cur_ctx),
    .wr_en   (stg_go && ch_ok),
    .wr_idx  (ch_idx),
    .wr_data (nxt_ctx)
  );

  lpd_step u_step (
    .in_word (stg_word),
    .cur     (cur_ctx),
    .nxt     (nxt_ctx),
    .emit    (step_emit),
    .res     (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_word <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stg_go && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && res_emit) begin
      out_data <= step_res;
    end
  end

`ifndef SYNTHESIS
  // accepted byte lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stg_valid)
    else $error("accepted byte not held in input register");

  // a byte blocked by a full output is kept, unchanged
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stg_valid && res_emit && !out_free |=> stg_valid && $stable(stg_word))
    else $error("blocked byte lost from input register");

  // a parsed result always reaches the output register
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    stg_go && res_emit |=> out_valid)
    else $error("parsed result not presented");

  // error results close the frame and carry no byte
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_error |-> out_data.frame_last && !out_data.has_byte)
    else $error("malformed error result");
`endif

endmodule

// File: src/lpd_chan_regs.sv
// ----------------------------------------------------------------------------
// lpd_chan_regs
// Per-channel parse context registers, one read and one write port.
// ----------------------------------------------------------------------------
module lpd_chan_regs
  import lpd_pkg::*;
#(
  parameter int DEPTH = NUM_CHANNELS_DEF,
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  rd_idx,
  output chan_state_t       rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  chan_state_t       wr_data
);

  chan_state_t ctx [DEPTH];

  // Context table, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ctx[i] <= '0;
      end
    end else if (wr_en) begin
      ctx[wr_idx] <= wr_data;
    end
  end

  // Read mux; out-of-range indexes read zero and the caller discards that result
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_idx == IDX_W'(i)) begin
        rd_data = ctx[i];
      end
    end
  end

endmodule

// File: src/lpd_step.sv
// ----------------------------------------------------------------------------
// lpd_step
// One parse step: consumes a byte against a channel context, returns the
// updated context and at most one result word.
// ----------------------------------------------------------------------------
module lpd_step
  import lpd_pkg::*;
(
  input  in_word_t    in_word,
  input  chan_state_t cur,
  output chan_state_t nxt,
  output logic        emit,
  output out_word_t   res
);

  logic [7:0]  b;
  logic [63:0] rem_dec;
  logic [3:0]  cnt;
  logic [3:0]  cnt_inc;
  logic [2:0]  lane_cnt;
  logic [5:0]  lane_base;

  assign b         = in_word.data_byte;
  assign rem_dec   = cur.remaining - 64'd1;
  assign cnt       = (cur.header_count >= HEADER_BYTES) ? 4'd0 : cur.header_count;
  assign cnt_inc   = cnt + 4'd1;
  assign lane_cnt  = 3'(cnt - MAGIC_BYTES);
  assign lane_base = {lane_cnt, 3'b000};

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '0;
    res.out_channel = in_word.channel;

    unique case (cur.phase)
      PH_OPCODE: begin
        nxt.opcode    = b;
        nxt.remaining = rem_dec;
        if (rem_dec == 64'd0) begin
          // opcode-only frame
          nxt.phase        = PH_HEADER;
          emit             = 1'b1;
          res.frame_opcode = b;
          res.frame_last   = 1'b1;
        end else begin
          nxt.phase = PH_MESSAGE;
        end
      end

      PH_MESSAGE: begin
        nxt.remaining    = rem_dec;
        emit             = 1'b1;
        res.frame_opcode = cur.opcode;
        res.message_byte = b;
        res.has_byte     = 1'b1;
        if (rem_dec == 64'd0) begin
          nxt.phase      = PH_HEADER;
          res.frame_last = 1'b1;
        end
      end

      default: begin
        // header bytes: magic low, magic high, then length LSB first
        if (cnt == 4'd0) begin
          nxt.magic     = {8'h00, b};
          nxt.remaining = '0;
        end else if (cnt == 4'd1) begin
          nxt.magic[15:8] = b;
        end else begin
          nxt.remaining[lane_base +: 8] = cur.remaining[lane_base +: 8] | b;
        end

        if (cnt_inc < HEADER_BYTES) begin
          nxt.header_count = cnt_inc;
          nxt.phase        = PH_HEADER;
        end else begin
          nxt.header_count = '0;
          if (nxt.remaining == 64'd0) begin
            // zero-length body: flag and go back to header
            nxt.phase       = PH_HEADER;
            nxt.opcode      = '0;
            emit            = 1'b1;
            res.frame_last  = 1'b1;
            res.frame_error = 1'b1;
          end else begin
            nxt.phase = PH_OPCODE;
          end
        end
      end
    endcase

    res.frame_magic = nxt.magic;
  end

endmodule

// File: tb/tb_length_prefixed_packet_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_deframer_core
// Self-checking bench for the per-channel length-prefixed frame deframer.
// Bytes are fed on interleaved channels and mostly form well-formed frames
// with random content. One channel also carries raw noise. A scoreboard keeps
// its own per-channel parse state and predicts every output word, which is
// compared field by field in order. Both sides of the handshake stall at
// random in the first two of three stretches; the third has no stalls.
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_deframer_core;
  import lpd_pkg::*;

  localparam int NUM_CH       = NUM_CHANNELS_DEF;
  localparam int NOISE_CH     = NUM_CH - 1;
  localparam int DIRECTED_N   = 21;
  localparam int TOTAL_BYTES  = DIRECTED_N + 600;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // Tracks per-channel parse state and the output words still owed
  class deframe_scoreboard;
    logic [1:0]  phase     [NUM_CH];
    logic [3:0]  hdr_count [NUM_CH];
    logic [15:0] magic     [NUM_CH];
    logic [63:0] remaining [NUM_CH];
    logic [7:0]  opcode    [NUM_CH];
    out_word_t   expected_words[$];
    int unsigned mismatches;

    function new();
      for (int c = 0; c < NUM_CH; c++) begin
        phase[c]     = PH_HEADER;
        hdr_count[c] = '0;
        magic[c]     = '0;
        remaining[c] = '0;
        opcode[c]    = '0;
      end
      mismatches = 0;
    endfunction

    function void owe(int unsigned ch, logic [7:0] opc, logic [7:0] b,
                      logic has, logic last, logic err);
      out_word_t w;
      w.out_channel  = ch[CHAN_W-1:0];
      w.frame_magic  = magic[ch];
      w.frame_opcode = opc;
      w.message_byte = b;
      w.has_byte     = has;
      w.frame_last   = last;
      w.frame_error  = err;
      expected_words.push_back(w);
    endfunction

    // Advance one channel's parser by one accepted byte
    function void note_byte(in_word_t w);
      int unsigned ch;
      int unsigned cnt;
      logic [7:0]  b;
      ch = w.channel;
      b  = w.data_byte;
      if (ch >= NUM_CH) return;
      case (phase[ch])
        PH_OPCODE: begin
          opcode[ch]    = b;
          remaining[ch] = remaining[ch] - 64'd1;
          if (remaining[ch] == '0) begin
            phase[ch] = PH_HEADER;
            owe(ch, b, 8'h00, 1'b0, 1'b1, 1'b0);
          end else begin
            phase[ch] = PH_MESSAGE;
          end
        end
        PH_MESSAGE: begin
          remaining[ch] = remaining[ch] - 64'd1;
          if (remaining[ch] == '0) begin
            phase[ch] = PH_HEADER;
            owe(ch, opcode[ch], b, 1'b1, 1'b1, 1'b0);
          end else begin
            owe(ch, opcode[ch], b, 1'b1, 1'b0, 1'b0);
          end
        end
        default: begin
          // header: two magic bytes then eight length bytes, LSB first
          cnt = hdr_count[ch];
          if (cnt >= HEADER_BYTES) cnt = 0;
          if (cnt == 0) begin
            magic[ch]     = {8'h00, b};
            remaining[ch] = '0;
          end else if (cnt == 1) begin
            magic[ch] = {b, magic[ch][7:0]};
          end else begin
            remaining[ch] = remaining[ch] | (64'(b) << (8 * (cnt - 2)));
          end
          cnt++;
          if (cnt < HEADER_BYTES) begin
            hdr_count[ch] = cnt[3:0];
            phase[ch]     = PH_HEADER;
          end else begin
            hdr_count[ch] = '0;
            if (remaining[ch] == '0) begin
              // zero-length body is flagged and parsing restarts
              phase[ch]  = PH_HEADER;
              opcode[ch] = '0;
              owe(ch, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
            end else begin
              phase[ch] = PH_OPCODE;
            end
          end
        end
      endcase
    endfunction

    function void report(string what, out_word_t want, out_word_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s: exp ch=%0d magic=%h op=%h byte=%h has=%b last=%b err=%b",
                 what, want.out_channel, want.frame_magic, want.frame_opcode,
                 want.message_byte, want.has_byte, want.frame_last,
                 want.frame_error);
        $display("  got ch=%0d magic=%h op=%h byte=%h has=%b last=%b err=%b",
                 got.out_channel, got.frame_magic, got.frame_opcode,
                 got.message_byte, got.has_byte, got.frame_last,
                 got.frame_error);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = expected_words.pop_front();
      if (got.out_channel  !== want.out_channel  ||
          got.frame_magic  !== want.frame_magic  ||
          got.frame_opcode !== want.frame_opcode ||
          got.message_byte !== want.message_byte ||
          got.has_byte     !== want.has_byte     ||
          got.frame_last   !== want.frame_last   ||
          got.frame_error  !== want.frame_error)
        report("word differs", want, got);
    endfunction

    function int unsigned owed();
      return expected_words.size();
    endfunction

    function int unsigned failures();
      return mismatches + expected_words.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned bytes_sent;
  deframe_scoreboard sb;
  logic [7:0] frame_bytes [NUM_CH][$];

  // zero-length header with all-ones magic, and a one-byte body with zero magic
  logic [7:0] zero_len_hdr [10] = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  logic [7:0] opcode_only  [11] = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                                    8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};

  length_prefixed_packet_deframer_core #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver stalls at random, changed on the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(out_data);
  end

  // Hard stop in case the block hangs
  initial begin
    #1000000;
    $display("length_prefixed_packet_deframer_core: mismatch");
    $finish;
  end

  // Offer one word, wait for acceptance; entered and left at a falling edge
  task automatic send_byte(input int unsigned ch, input logic [7:0] b);
    in_word_t w;
    case (bytes_sent * 3 / TOTAL_BYTES)
      0:       begin src_idle_pct = 26; snk_idle_pct = 85; end
      1:       begin src_idle_pct = 85; snk_idle_pct = 26; end
      default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
    endcase
    w.channel   = ch[CHAN_W-1:0];
    w.data_byte = b;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(w);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Queue a frame, or raw noise on the noise channel
  task automatic queue_frame(input int unsigned ch);
    int unsigned sel;
    logic [15:0] magic;
    logic [63:0] len;
    sel   = $urandom_range(0, 99);
    magic = 16'($urandom);
    if (ch == NOISE_CH && sel < 40) begin
      repeat ($urandom_range(1, 12)) frame_bytes[ch].push_back(8'($urandom));
      return;
    end
    if (sel < 12)      len = 64'd0;
    else if (sel < 25) len = 64'd1;
    else if (sel < 90) len = 64'($urandom_range(2, 8));
    else               len = 64'($urandom_range(9, 40));
    frame_bytes[ch].push_back(magic[7:0]);
    frame_bytes[ch].push_back(magic[15:8]);
    for (int i = 0; i < 8; i++) frame_bytes[ch].push_back(len[8*i +: 8]);
    if (len != '0) begin
      frame_bytes[ch].push_back(8'($urandom));
      for (int i = 1; i < int'(len); i++) frame_bytes[ch].push_back(8'($urandom));
    end
  endtask

  // Main stimulus
  initial begin
    int unsigned sel;
    int unsigned ch;
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    bytes_sent   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero-length frame on the top channel interleaved with an opcode-only
    // frame on channel 0
    for (int i = 0; i < 11; i++) begin
      if (i < 10) send_byte(NOISE_CH, zero_len_hdr[i]);
      send_byte(0, opcode_only[i]);
    end

    // random interleaved frames, biased toward a few channels
    while (bytes_sent < TOTAL_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 60)      ch = $urandom_range(0, 3);
      else if (sel < 75) ch = NOISE_CH;
      else               ch = $urandom_range(0, NUM_CH - 1);
      if (frame_bytes[ch].size() == 0) queue_frame(ch);
      send_byte(ch, frame_bytes[ch].pop_front());
    end
    in_valid <= 1'b0;

    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("length_prefixed_packet_deframer_core: match");
    end else begin
      $display("length_prefixed_packet_deframer_core: mismatch");
    end
    $finish;
  end

endmodule

// File: length_prefixed_packet_deframer_core.f
src/lpd_pkg.sv
src/lpd_chan_regs.sv
src/lpd_step.sv
src/length_prefixed_packet_deframer_core.sv
tb/tb_length_prefixed_packet_deframer_core.sv
